FILE: hdl/ecpr_pkg.sv
// Shared constants, payload types and sequencer states for the enhanced clock replacer.
`timescale 1ns / 1ps

package ecpr_pkg;

    // Ring geometry: frames 0..FRAMES-1 plus one sentinel node at index FRAMES
    localparam int FRAMES      = 64;
    localparam int NODES       = FRAMES + 1;
    localparam int NODE_W      = $clog2(NODES);
    localparam int FRAME_IDX_W = $clog2(FRAMES);
    localparam int COUNT_W     = $clog2(FRAMES + 1);

    // Fixed field widths of the transaction payloads
    localparam int ACTION_W = 2;
    localparam int FRAME_W  = 6;

    localparam logic [NODE_W-1:0] SENT = NODE_W'(FRAMES);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACCESS = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVICT  = 2'd2;

    // Status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FRAME_W-1:0]  frame;
        logic                set_accessed;
        logic                set_dirty;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_valid;
        logic               status;
    } t_rsp;

    typedef struct packed {
        logic accessed;
        logic dirty;
    } t_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_LINK,
        S_ACC_UPD,
        S_EV_HEAD,
        S_EV_VISIT,
        S_EV_CLEAR,
        S_DONE
    } t_state;

endpackage

FILE: hdl/ecpr_req_if.sv
// Request channel: valid/ready handshake carrying one replacement command.
`timescale 1ns / 1ps

interface ecpr_req_if;
    import ecpr_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ecpr_rsp_if.sv
// Response channel: valid/ready handshake carrying one replacement result.
`timescale 1ns / 1ps

interface ecpr_rsp_if;
    import ecpr_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/enhanced_clock_page_replacement.sv
// Enhanced second-chance clock replacer: link tables, flag store and sweep sequencer.
`timescale 1ns / 1ps
//
// Usage
//   i_req carries one command per transaction: insert a frame before the hand,
//   record an access (OR in accessed/dirty), or evict. Every command returns
//   exactly one transaction on o_rsp: victim_frame/victim_valid for an evict
//   that found a victim, status = 1 for an evict on an empty ring, zeros else.
//   One command is in flight at a time; i_req.ready is high only when idle.
//   An evict lets the hand visit frames until it finds a clean one. Each visit
//   is one read of the link and flag memories through a single sweep step, and
//   a frame is visited at most three times.
//   Reset clears the hand to the sentinel, the resident count, and the valid
//   bits of all three memories, so every node reads as linked to itself and
//   every flag pair reads as zero; no clearing pass is needed.
//   A finished result waits in the output register while o_rsp.ready is low;
//   the next command is accepted meanwhile and stalls only when its own
//   result finds the output register still occupied.
//
module enhanced_clock_page_replacement (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ecpr_req_if.sink   i_req,
    ecpr_rsp_if.source o_rsp
);
    import ecpr_pkg::*;

    // Sequencer and architectural state
    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_hand, n_hand;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [NODE_W-1:0]  r_cur, n_cur;
    logic [NODE_W-1:0]  r_head, n_head;
    logic [NODE_W-1:0]  r_link, n_link;
    t_rsp               r_res, n_res;
    t_req               r_req;
    logic               r_out_vld;
    t_rsp               r_out_data;

    // Successor table
    logic [NODE_W-1:0] r_succ_mem [NODES];
    logic [NODES-1:0]  r_succ_vld;
    logic [NODE_W-1:0] r_succ_raw, r_succ_ra;
    logic              r_succ_rv;
    logic [NODE_W-1:0] succ_ra, succ_wa, succ_wd, succ_q;
    logic              succ_we;

    // Predecessor table
    logic [NODE_W-1:0] r_pred_mem [NODES];
    logic [NODES-1:0]  r_pred_vld;
    logic [NODE_W-1:0] r_pred_raw, r_pred_ra;
    logic              r_pred_rv;
    logic [NODE_W-1:0] pred_ra, pred_wa, pred_wd, pred_q;
    logic              pred_we;

    // Accessed/dirty flag store
    t_flags                 r_bits_mem [FRAMES];
    logic [FRAMES-1:0]      r_bits_vld;
    t_flags                 r_bits_raw;
    logic                   r_bits_rv;
    logic [FRAME_IDX_W-1:0] bits_ra, bits_wa;
    t_flags                 bits_wd, bits_q;
    logic                   bits_we;

    logic              accept;
    logic              out_load;
    logic              in_range;
    logic [NODE_W-1:0] req_node;
    logic [NODE_W-1:0] f_node;
    logic [NODE_W-1:0] ev_next;
    t_flags            set_flags;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out_data;
    assign out_load    = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    assign in_range  = int'(i_req.data.frame) < FRAMES;
    assign req_node  = NODE_W'(i_req.data.frame);
    assign f_node    = NODE_W'(r_req.frame);
    assign set_flags = '{accessed: r_req.set_accessed, dirty: r_req.set_dirty};

    // Unwritten entries read as their reset value
    assign succ_q = r_succ_rv ? r_succ_raw : r_succ_ra;
    assign pred_q = r_pred_rv ? r_pred_raw : r_pred_ra;
    assign bits_q = r_bits_rv ? r_bits_raw : '0;

    // Hand step: skip the sentinel
    assign ev_next = (succ_q == SENT) ? r_head : succ_q;

    // Successor memory, read-first with write bypass
    always_ff @(posedge i_clk) begin
        if (succ_we) begin
            r_succ_mem[succ_wa] <= succ_wd;
        end
        if (succ_we && succ_wa == succ_ra) begin
            r_succ_raw <= succ_wd;
        end else begin
            r_succ_raw <= r_succ_mem[succ_ra];
        end
        r_succ_ra <= succ_ra;
    end

    // Predecessor memory, read-first with write bypass
    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            r_pred_mem[pred_wa] <= pred_wd;
        end
        if (pred_we && pred_wa == pred_ra) begin
            r_pred_raw <= pred_wd;
        end else begin
            r_pred_raw <= r_pred_mem[pred_ra];
        end
        r_pred_ra <= pred_ra;
    end

    // Flag memory, read-first with write bypass
    always_ff @(posedge i_clk) begin
        if (bits_we) begin
            r_bits_mem[bits_wa] <= bits_wd;
        end
        if (bits_we && bits_wa == bits_ra) begin
            r_bits_raw <= bits_wd;
        end else begin
            r_bits_raw <= r_bits_mem[bits_ra];
        end
    end

    // Track written entries of all three memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_succ_vld <= '0;
            r_pred_vld <= '0;
            r_bits_vld <= '0;
            r_succ_rv  <= 1'b0;
            r_pred_rv  <= 1'b0;
            r_bits_rv  <= 1'b0;
        end else begin
            if (succ_we) begin
                r_succ_vld[succ_wa] <= 1'b1;
            end
            if (pred_we) begin
                r_pred_vld[pred_wa] <= 1'b1;
            end
            if (bits_we) begin
                r_bits_vld[bits_wa] <= 1'b1;
            end
            r_succ_rv <= r_succ_vld[succ_ra] || (succ_we && succ_wa == succ_ra);
            r_pred_rv <= r_pred_vld[pred_ra] || (pred_we && pred_wa == pred_ra);
            r_bits_rv <= r_bits_vld[bits_ra] || (bits_we && bits_wa == bits_ra);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hand    <= SENT;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_count <= n_count;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_head <= n_head;
        r_link <= n_link;
        r_res  <= n_res;
        if (accept) begin
            r_req <= i_req.data;
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    // Sequencer: next state, memory accesses and result
    always_comb begin
        n_state = r_state;
        n_hand  = r_hand;
        n_count = r_count;
        n_cur   = r_cur;
        n_head  = r_head;
        n_link  = r_link;
        n_res   = r_res;
        succ_ra = r_cur;
        pred_ra = r_cur;
        bits_ra = r_cur[FRAME_IDX_W-1:0];
        succ_we = 1'b0;
        succ_wa = r_cur;
        succ_wd = r_cur;
        pred_we = 1'b0;
        pred_wa = r_cur;
        pred_wd = r_cur;
        bits_we = 1'b0;
        bits_wa = f_node[FRAME_IDX_W-1:0];
        bits_wd = set_flags;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '{victim_frame: '0, victim_valid: 1'b0, status: ST_OK};
                    n_state = S_DONE;
                    case (i_req.data.action)
                        ACT_INSERT: begin
                            if (in_range) begin
                                succ_ra = req_node;
                                pred_ra = r_hand;
                                n_state = S_INS_CHK;
                            end
                        end
                        ACT_ACCESS: begin
                            if (in_range) begin
                                bits_ra = req_node[FRAME_IDX_W-1:0];
                                n_state = S_ACC_UPD;
                            end
                        end
                        ACT_EVICT: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                succ_ra = SENT;
                                n_state = S_EV_HEAD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Resident frames keep their place; others link in before the hand
            S_INS_CHK: begin
                if (succ_q != f_node) begin
                    bits_we = 1'b1;
                    n_state = S_DONE;
                end else begin
                    succ_we = 1'b1;
                    succ_wa = f_node;
                    succ_wd = r_hand;
                    pred_we = 1'b1;
                    pred_wa = f_node;
                    pred_wd = pred_q;
                    n_link  = pred_q;
                    n_state = S_INS_LINK;
                end
            end

            S_INS_LINK: begin
                succ_we = 1'b1;
                succ_wa = r_link;
                succ_wd = f_node;
                pred_we = 1'b1;
                pred_wa = r_hand;
                pred_wd = f_node;
                bits_we = 1'b1;
                n_count = r_count + COUNT_W'(1);
                n_state = S_DONE;
            end

            // OR in the new flags
            S_ACC_UPD: begin
                bits_we = 1'b1;
                bits_wd = '{accessed: bits_q.accessed | r_req.set_accessed,
                            dirty:    bits_q.dirty    | r_req.set_dirty};
                n_state = S_DONE;
            end

            // Latch the first frame after the sentinel and start the sweep
            S_EV_HEAD: begin
                if (succ_q == SENT) begin
                    n_res.status = ST_EMPTY;
                    n_state = S_DONE;
                end else begin
                    n_head  = succ_q;
                    n_cur   = (r_hand >= SENT) ? succ_q : r_hand;
                    succ_ra = n_cur;
                    pred_ra = n_cur;
                    bits_ra = n_cur[FRAME_IDX_W-1:0];
                    n_state = S_EV_VISIT;
                end
            end

            // One frame per cycle: take a clean frame, else age its flags
            S_EV_VISIT: begin
                if (!bits_q.accessed && !bits_q.dirty) begin
                    succ_we = 1'b1;
                    succ_wa = pred_q;
                    succ_wd = succ_q;
                    pred_we = 1'b1;
                    pred_wa = succ_q;
                    pred_wd = pred_q;
                    n_hand  = succ_q;
                    n_count = r_count - COUNT_W'(1);
                    n_res.victim_frame = FRAME_W'(r_cur);
                    n_res.victim_valid = 1'b1;
                    n_state = S_EV_CLEAR;
                end else begin
                    bits_we = 1'b1;
                    bits_wa = r_cur[FRAME_IDX_W-1:0];
                    bits_wd = '{accessed: 1'b0, dirty: bits_q.accessed & bits_q.dirty};
                    n_cur   = ev_next;
                    succ_ra = ev_next;
                    pred_ra = ev_next;
                    bits_ra = ev_next[FRAME_IDX_W-1:0];
                end
            end

            // Point the victim back at itself
            S_EV_CLEAR: begin
                succ_we = 1'b1;
                pred_we = 1'b1;
                n_state = S_DONE;
            end

            // Hold the result until the output register frees up
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/ecpr_chk.sv
// Port-level checker for the enhanced clock replacer, bound to the top level.
`timescale 1ns / 1ps

module ecpr_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input ecpr_pkg::t_rsp i_rsp_data
);
    import ecpr_pkg::*;

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // Drop ready after a request transaction: one command in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while a command is in flight");

    // Never report a victim and an empty-ring error together
    a_rsp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_data.victim_valid && i_rsp_data.status == ST_EMPTY))
        else $error("victim reported with empty-ring status");

    // Zero the frame field when no victim is reported
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.victim_valid |-> i_rsp_data.victim_frame == '0)
        else $error("victim frame nonzero without a victim");

endmodule

bind enhanced_clock_page_replacement ecpr_chk u_ecpr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

FILE: dv/enhanced_clock_page_replacement_tb.sv
// Self-checking testbench for the enhanced clock replacer: directed and random command streams.
`timescale 1ns / 1ps

module enhanced_clock_page_replacement_tb;
    import ecpr_pkg::*;

    // Action code the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // The stall limit leaves wide margin over the longest evict
    localparam int DRAIN_CYCLES    = 2 * FRAMES + 30;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SWEEP_BOUND     = 3 * FRAMES + 3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ecpr_req_if req_bus ();
    ecpr_rsp_if rsp_bus ();

    enhanced_clock_page_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // Shadow ring: link tables, flag bits, hand and occupancy
    logic [NODE_W-1:0] ring_next [0:NODES-1];
    logic [NODE_W-1:0] ring_prev [0:NODES-1];
    logic              acc_bit   [0:FRAMES-1];
    logic              dirty_bit [0:FRAMES-1];
    logic [NODE_W-1:0] clock_hand;
    int                resident_total;

    t_rsp pending_results [$];
    int   mismatches;
    int   idle_cycles;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    // Free-running clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_ring_shadow();
        for (int i = 0; i < NODES; i++) begin
            ring_next[i] = NODE_W'(i);
            ring_prev[i] = NODE_W'(i);
        end
        for (int i = 0; i < FRAMES; i++) begin
            acc_bit[i]   = 1'b0;
            dirty_bit[i] = 1'b0;
        end
        clock_hand     = SENT;
        resident_total = 0;
    endfunction

    // Apply one command to the shadow ring and return the result it yields
    function automatic t_rsp clock_replace_step(input t_req cmd);
        t_rsp              res;
        logic [NODE_W-1:0] fidx;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] p;
        logic [NODE_W-1:0] n;
        int                steps;
        res  = '0;
        fidx = NODE_W'(cmd.frame);
        case (cmd.action)
            ACT_INSERT: begin
                // Link a non-resident frame in just before the hand
                if (ring_next[fidx] == fidx) begin
                    p                     = ring_prev[clock_hand];
                    ring_next[fidx]       = clock_hand;
                    ring_prev[fidx]       = p;
                    ring_next[p]          = fidx;
                    ring_prev[clock_hand] = fidx;
                    resident_total++;
                end
                acc_bit[fidx]   = cmd.set_accessed;
                dirty_bit[fidx] = cmd.set_dirty;
            end
            ACT_ACCESS: begin
                acc_bit[fidx]   = acc_bit[fidx] | cmd.set_accessed;
                dirty_bit[fidx] = dirty_bit[fidx] | cmd.set_dirty;
            end
            ACT_EVICT: begin
                if (resident_total == 0 || ring_next[SENT] == SENT) begin
                    res.status = ST_EMPTY;
                end else begin
                    cur   = (clock_hand == SENT) ? ring_next[SENT] : clock_hand;
                    steps = 0;
                    // Sweep: both set drops accessed, one set drops both
                    while (steps < SWEEP_BOUND && cur != SENT &&
                           (acc_bit[cur] || dirty_bit[cur])) begin
                        if (!(acc_bit[cur] && dirty_bit[cur]))
                            dirty_bit[cur] = 1'b0;
                        acc_bit[cur] = 1'b0;
                        cur = ring_next[cur];
                        if (cur == SENT)
                            cur = ring_next[SENT];
                        steps++;
                    end
                    if (cur != SENT) begin
                        clock_hand     = ring_next[cur];
                        n              = ring_next[cur];
                        p              = ring_prev[cur];
                        ring_next[p]   = n;
                        ring_prev[n]   = p;
                        ring_next[cur] = cur;
                        ring_prev[cur] = cur;
                        resident_total--;
                        res.victim_frame = cur[FRAME_W-1:0];
                        res.victim_valid = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Record accepted commands, check accepted results, guard against hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready)
                pending_results.push_back(clock_replace_step(req_bus.data));
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result frame=%0d valid=%0b status=%0b",
                             $time, rsp_bus.data.victim_frame,
                             rsp_bus.data.victim_valid, rsp_bus.data.status);
                end else begin
                    if (rsp_bus.data !== pending_results[0]) begin
                        mismatches++;
                        $display("%0t: expected frame=%0d valid=%0b status=%0b, %s%0d %s%0b %s%0b",
                                 $time, pending_results[0].victim_frame,
                                 pending_results[0].victim_valid, pending_results[0].status,
                                 "got frame=", rsp_bus.data.victim_frame,
                                 "valid=", rsp_bus.data.victim_valid,
                                 "status=", rsp_bus.data.status);
                    end
                    void'(pending_results.pop_front());
                end
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic t_req make_cmd(input logic [ACTION_W-1:0] action, input int frame,
                                      input logic acc, input logic dirty);
        t_req cmd;
        cmd.action       = action;
        cmd.frame        = FRAME_W'(frame);
        cmd.set_accessed = acc;
        cmd.set_dirty    = dirty;
        return cmd;
    endfunction

    // Drive one transaction on the command channel, then drop valid
    task automatic send_cmd(input t_req cmd);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct)
            @(negedge i_clk);
        req_bus.valid <= 1'b1;
        req_bus.data  <= cmd;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_ring_evict();
        send_cmd(make_cmd(ACT_EVICT, 0, 1'b0, 1'b0));
        send_cmd(make_cmd(ACT_UNUSED, 63, 1'b1, 1'b1));
        send_cmd(make_cmd(ACT_EVICT, 63, 1'b1, 1'b1));
    endtask

    task automatic test_insert_and_access();
        // Bits set on a non-resident frame are later overwritten by its insert
        send_cmd(make_cmd(ACT_ACCESS, 5, 1'b1, 1'b1));
        send_cmd(make_cmd(ACT_INSERT, 0, 1'b0, 1'b0));
        send_cmd(make_cmd(ACT_INSERT, 63, 1'b1, 1'b1));
        send_cmd(make_cmd(ACT_INSERT, 5, 1'b0, 1'b1));
        send_cmd(make_cmd(ACT_INSERT, 20, 1'b1, 1'b0));
        // Re-insert of a resident frame rewrites bits only
        send_cmd(make_cmd(ACT_INSERT, 63, 1'b0, 1'b0));
        send_cmd(make_cmd(ACT_ACCESS, 0, 1'b1, 1'b0));
        send_cmd(make_cmd(ACT_ACCESS, 20, 1'b0, 1'b1));
        send_cmd(make_cmd(ACT_ACCESS, 63, 1'b0, 1'b0));
        send_cmd(make_cmd(ACT_UNUSED, 0, 1'b0, 1'b0));
    endtask

    task automatic test_sweep_to_empty();
        // Drain every resident frame, then evict once more on the empty ring
        for (int i = 0; i < 5; i++)
            send_cmd(make_cmd(ACT_EVICT, i, 1'b0, 1'b0));
    endtask

    task automatic test_full_ring_sweep();
        // Every frame with both bits set forces the longest sweep
        for (int f = 0; f < FRAMES; f++)
            send_cmd(make_cmd(ACT_INSERT, f, 1'b1, 1'b1));
        for (int i = 0; i < 3; i++)
            send_cmd(make_cmd(ACT_EVICT, 0, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        t_req cmd;
        int   pick;
        int   sent;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 36)
                cmd.action = ACT_INSERT;
            else if (pick < 66)
                cmd.action = ACT_ACCESS;
            else if (pick < 96)
                cmd.action = ACT_EVICT;
            else
                cmd.action = ACT_UNUSED;
            // Favor a few low frames so accesses often hit resident frames
            cmd.frame = $urandom_range(1) ? FRAME_W'($urandom_range(15))
                                          : FRAME_W'($urandom_range(FRAMES - 1));
            cmd.set_accessed = 1'($urandom_range(1));
            cmd.set_dirty    = 1'($urandom_range(1));
            send_cmd(cmd);
            if (cmd.action != ACT_UNUSED)
                sent++;
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.data       = '0;
        rsp_bus.ready      = 1'b0;
        mismatches         = 0;
        idle_cycles        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        clear_ring_shadow();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ring_evict();
        test_insert_and_access();
        test_sweep_to_empty();
        test_full_ring_sweep();
        wait_for_results();
        test_random_traffic(135, 0, 0);
        test_random_traffic(135, 80, 0);
        test_random_traffic(135, 0, 80);
        test_random_traffic(135, 24, 24);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ecpr_pkg.sv
hdl/ecpr_req_if.sv
hdl/ecpr_rsp_if.sv
hdl/enhanced_clock_page_replacement.sv
hdl/ecpr_chk.sv
dv/enhanced_clock_page_replacement_tb.sv
